// ===== rtl/core/cpf_pkg.sv =====
`default_nettype none
package cpf_pkg;

  // Template and ring depth, and datapath widths
  localparam int unsigned MaxTaps   = 1024;
  localparam int unsigned AddrBits  = 10;
  localparam int unsigned LenBits   = 11;
  localparam int unsigned CountBits = 25;
  localparam int unsigned StartBits = 24;
  localparam int unsigned MagBits   = 41;
  localparam int unsigned AccBits   = 42;
  localparam int unsigned NumBits   = 48;
  localparam int unsigned DenBits   = 44;
  localparam int unsigned PosBits   = 32;

  // Input actions
  localparam logic [1:0] ACT_TAP    = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TEMPLATE_LENGTH = 2'd0;
  localparam logic [1:0] CFG_SEARCH_START    = 2'd1;
  localparam logic [1:0] CFG_SEARCH_END      = 2'd2;

  // Neighbor flag bits
  localparam int unsigned FLAG_LEFT  = 0;
  localparam int unsigned FLAG_RIGHT = 1;
  localparam int unsigned FLAG_PREV  = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_UPDATE,
    ST_DIV_SETUP,
    ST_DIV,
    ST_FIN
  } state_t;

  // Divider handshake toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/cpf_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle, signed result truncated to zero
module cpf_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [cpf_pkg::NumBits-1:0]         num_mag,
  input  wire logic [cpf_pkg::DenBits-1:0]         den_mag,
  input  wire logic                                neg,
  output cpf_pkg::div_status_t                     status,
  output logic      [cpf_pkg::PosBits-1:0]         quot
);

  localparam int unsigned CntBits = $clog2(cpf_pkg::NumBits + 1);

  logic [cpf_pkg::DenBits-1:0] rem;
  logic [cpf_pkg::NumBits-1:0] q;
  logic [cpf_pkg::DenBits-1:0] dmag;
  logic                        sign;
  logic [CntBits-1:0]          cnt;
  logic                        busy;
  logic                        done;
  logic [cpf_pkg::DenBits:0]   rem_sh;
  logic [cpf_pkg::DenBits:0]   rem_sub;

  // Shift in the next numerator bit and trial-subtract
  always_comb begin
    rem_sh  = {rem, q[cpf_pkg::NumBits-1]};
    rem_sub = rem_sh - {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntBits'(cpf_pkg::NumBits);
      end else if (busy) begin
        cnt <= cnt - CntBits'(1);
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      q    <= num_mag;
      dmag <= den_mag;
      sign <= neg;
    end else if (busy) begin
      if (!rem_sub[cpf_pkg::DenBits]) begin
        rem <= rem_sub[cpf_pkg::DenBits-1:0];
        q   <= {q[cpf_pkg::NumBits-2:0], 1'b1};
      end else begin
        rem <= rem_sh[cpf_pkg::DenBits-1:0];
        q   <= {q[cpf_pkg::NumBits-2:0], 1'b0};
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quot = sign ? (cpf_pkg::PosBits'(0) - q[cpf_pkg::PosBits-1:0])
                     : q[cpf_pkg::PosBits-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/correlation_peak_finder.sv =====
`default_nettype none
// Correlation peak finder.
// Input channel (in_valid/in_ready) carries one beat per action: load a
// template tap, push a signal sample, or end the stream. Config registers
// (template_length, search_start, search_end) are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block does not enforce. After a tap beat the block stays
// idle. A sample beat whose window falls inside the search range runs one
// shared multiply-accumulate over the template, with one tap/sample read per
// cycle from the two memories through the read, multiply and accumulate
// pipeline; no new beat is taken until it is done. Other sample beats leave
// the block idle. An end-of-stream beat gives one result beat on
// out_valid/out_ready, via the bit-serial divider for parabolic refinement
// when refinement applies. Tap and sample beats are still taken while a
// result waits in the output register; an end beat's result waits until
// that register is free. Reset clears stream state and returns config to
// its defaults; template taps stay undefined until loaded.
module correlation_peak_finder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [9:0]  tap_index,
  input  wire logic signed [15:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      peak_position_q8,
  output logic [40:0]      peak_magnitude,
  output logic             enough_samples,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [24:0] cfg_data
);

  localparam int unsigned AB = cpf_pkg::AddrBits;
  localparam int unsigned LB = cpf_pkg::LenBits;
  localparam int unsigned CB = cpf_pkg::CountBits;
  localparam int unsigned SB = cpf_pkg::StartBits;
  localparam int unsigned MB = cpf_pkg::MagBits;
  localparam int unsigned XB = cpf_pkg::AccBits;
  localparam int unsigned DB = cpf_pkg::DenBits;

  // Memories
  logic signed [15:0] taps [cpf_pkg::MaxTaps];
  logic signed [15:0] ring [cpf_pkg::MaxTaps];

  // Config
  logic [LB-1:0] template_length;
  logic [SB-1:0] search_start;
  logic [CB-1:0] search_end;

  // Stream state
  logic [CB-1:0] sample_count;
  logic [MB-1:0] best_magnitude;
  logic [SB-1:0] best_start;
  logic [MB-1:0] previous_corr;
  logic [MB-1:0] left_neighbour;
  logic [MB-1:0] right_neighbour;
  logic [2:0]    flags;

  // Control and datapath
  cpf_pkg::state_t state, state_next;
  logic [CB-1:0]   win_start;
  logic [AB-1:0]   idx;
  logic            v1, v2;
  logic signed [15:0] tap_rd, smp_rd;
  logic signed [31:0] prod;
  logic signed [XB-1:0] acc;
  logic            enough;
  logic [31:0]     quot;

  logic          accept;
  logic [LB-1:0] len;
  logic [AB-1:0] last_idx;
  logic [CB-1:0] count_inc;
  logic [CB-1:0] s_new;
  logic          win_hit;
  logic [MB-1:0] mag;
  logic [DB-1:0] den;
  logic [XB-1:0] diff;
  logic [MB-1:0] diff_mag;
  logic          refine;
  logic          div_start;
  logic          out_load;
  cpf_pkg::div_status_t div_status;
  logic [31:0]   div_quot;

  // Taps in use, clamped to 1..MaxTaps
  always_comb begin
    if (template_length == '0) begin
      len = LB'(1);
    end else if (template_length > LB'(cpf_pkg::MaxTaps)) begin
      len = LB'(cpf_pkg::MaxTaps);
    end else begin
      len = template_length;
    end
  end
  assign last_idx = AB'(len - LB'(1));

  assign accept    = in_valid && in_ready;
  assign count_inc = sample_count + CB'(1);
  assign s_new     = count_inc - CB'(len);
  assign win_hit   = (count_inc >= CB'(len)) && (s_new >= CB'(search_start))
                     && (s_new < search_end);

  // Correlation magnitude
  assign mag = acc[XB-1] ? MB'(XB'(0) - acc) : acc[MB-1:0];

  // Parabolic refinement terms
  assign den  = DB'(left_neighbour) - DB'({best_magnitude, 1'b0}) + DB'(right_neighbour);
  assign diff = XB'(left_neighbour) - XB'(right_neighbour);
  assign diff_mag = diff[XB-1] ? MB'(XB'(0) - diff) : diff[MB-1:0];
  assign refine = (best_magnitude != '0) && flags[cpf_pkg::FLAG_LEFT]
                  && flags[cpf_pkg::FLAG_RIGHT] && (den != '0);
  assign div_start = (state == cpf_pkg::ST_DIV_SETUP) && refine;
  assign out_load  = (state == cpf_pkg::ST_FIN) && (!out_valid || out_ready);

  cpf_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num_mag ({diff_mag, 7'd0}),
    .den_mag (den[DB-1] ? (DB'(0) - den) : den),
    .neg     (diff[XB-1] ^ den[DB-1]),
    .status  (div_status),
    .quot    (div_quot)
  );

  // Next state
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      cpf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == cpf_pkg::ACT_SAMPLE && sample_count != {CB{1'b1}} && win_hit) begin
            state_next = cpf_pkg::ST_MAC;
          end else if (action == cpf_pkg::ACT_END) begin
            state_next = cpf_pkg::ST_DIV_SETUP;
          end
        end
      end
      cpf_pkg::ST_MAC: begin
        if (idx == last_idx) state_next = cpf_pkg::ST_DRAIN;
      end
      cpf_pkg::ST_DRAIN: begin
        if (!v1 && !v2) state_next = cpf_pkg::ST_UPDATE;
      end
      cpf_pkg::ST_UPDATE: state_next = cpf_pkg::ST_IDLE;
      cpf_pkg::ST_DIV_SETUP: begin
        state_next = refine ? cpf_pkg::ST_DIV : cpf_pkg::ST_FIN;
      end
      cpf_pkg::ST_DIV: begin
        if (div_status.done) state_next = cpf_pkg::ST_FIN;
      end
      cpf_pkg::ST_FIN: begin
        if (out_load) state_next = cpf_pkg::ST_IDLE;
      end
      default: state_next = cpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      template_length <= LB'(cpf_pkg::MaxTaps);
      search_start    <= '0;
      search_end      <= CB'(25'h1000000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpf_pkg::CFG_TEMPLATE_LENGTH: template_length <= cfg_data[LB-1:0];
        cpf_pkg::CFG_SEARCH_START:    search_start    <= cfg_data[SB-1:0];
        cpf_pkg::CFG_SEARCH_END:      search_end      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memory writes and registered reads
  always_ff @(posedge clk) begin
    if (accept && action == cpf_pkg::ACT_TAP) begin
      taps[tap_index] <= value;
    end
    if (accept && action == cpf_pkg::ACT_SAMPLE && sample_count != {CB{1'b1}}) begin
      ring[sample_count[AB-1:0]] <= value;
    end
    tap_rd <= taps[idx];
    smp_rd <= ring[win_start[AB-1:0] + idx];
  end

  // Multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == cpf_pkg::ST_MAC);
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 32'(tap_rd) * 32'(smp_rd);
    if (accept) begin
      win_start <= s_new;
      idx       <= '0;
      acc       <= '0;
    end else begin
      if (state == cpf_pkg::ST_MAC) idx <= idx + AB'(1);
      if (v2) acc <= acc + XB'(prod);
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= '0;
      best_magnitude  <= '0;
      best_start      <= '0;
      previous_corr   <= '0;
      left_neighbour  <= '0;
      right_neighbour <= '0;
      flags           <= '0;
    end else if (out_load) begin
      sample_count    <= '0;
      best_magnitude  <= '0;
      best_start      <= '0;
      previous_corr   <= '0;
      left_neighbour  <= '0;
      right_neighbour <= '0;
      flags           <= '0;
    end else begin
      if (accept && action == cpf_pkg::ACT_SAMPLE && sample_count != {CB{1'b1}}) begin
        sample_count <= count_inc;
      end
      if (state == cpf_pkg::ST_UPDATE) begin
        if (mag > best_magnitude) begin
          best_magnitude <= mag;
          best_start     <= win_start[SB-1:0];
          left_neighbour <= previous_corr;
          flags[cpf_pkg::FLAG_LEFT]  <= flags[cpf_pkg::FLAG_PREV];
          flags[cpf_pkg::FLAG_RIGHT] <= 1'b0;
        end else if (best_magnitude != '0 && win_start == ({1'b0, best_start} + CB'(1))
                     && !flags[cpf_pkg::FLAG_RIGHT]) begin
          right_neighbour <= mag;
          flags[cpf_pkg::FLAG_RIGHT] <= 1'b1;
        end
        previous_corr <= mag;
        flags[cpf_pkg::FLAG_PREV] <= 1'b1;
      end
    end
  end

  // End-of-stream capture
  always_ff @(posedge clk) begin
    if (accept && action == cpf_pkg::ACT_END) begin
      enough <= (sample_count >= CB'(len));
    end
    if (state == cpf_pkg::ST_DIV_SETUP) begin
      quot <= '0;
    end else if (state == cpf_pkg::ST_DIV && div_status.done) begin
      quot <= div_quot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      peak_magnitude   <= best_magnitude;
      enough_samples   <= enough;
      peak_position_q8 <= (best_magnitude == '0) ? 32'd0 : ({best_start, 8'd0} + quot);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cpf_checker.sv =====
`default_nettype none
module cpf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] peak_position_q8,
  input wire logic [40:0] peak_magnitude,
  input wire logic        enough_samples
);

  // Result beat holds under stall
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped under stall");

  // No peak means position zero
  a_zero_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && peak_magnitude == 41'd0 |-> peak_position_q8 == 32'd0)
    else $error("position set without a peak");

  // Short stream cannot carry a peak
  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && !enough_samples |-> peak_magnitude == 41'd0)
    else $error("peak reported on short stream");

endmodule

bind correlation_peak_finder cpf_checker u_cpf_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .peak_position_q8 (peak_position_q8),
  .peak_magnitude   (peak_magnitude),
  .enough_samples   (enough_samples)
);
`default_nettype wire
